[src/assert_macros.svh]
// Assertion shorthands used by the top-level RTL file of the spanning-forest unit.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ufsf_pkg.sv]
// Package for the union-find spanning-forest unit: field widths, defaults and
// the sequencer state type. No dependencies.
package ufsf_pkg;

  localparam int NODE_W    = 10;
  localparam int WEIGHT_W  = 32;
  localparam int TOTAL_W   = 48;
  localparam int NODES_DEF = 1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_COMP,
    ST_LINK
  } ufsf_state_t;

endpackage

[src/ufsf_ifs.sv]
// Valid/ready channel interfaces for the spanning-forest unit: edge items in,
// result items out. Depends on ufsf_pkg for the field widths.
interface ufsf_edge_if
  import ufsf_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;
  logic [WEIGHT_W-1:0] edge_weight;
  logic                last_edge;

  modport source (output valid, output node_a, output node_b, output edge_weight,
                  output last_edge, input ready);
  modport sink   (input valid, input node_a, input node_b, input edge_weight,
                  input last_edge, output ready);
endinterface

interface ufsf_result_if
  import ufsf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               joined;
  logic [TOTAL_W-1:0] tree_weight;

  modport source (output valid, output joined, output tree_weight, input ready);
  modport sink   (input valid, input joined, input tree_weight, output ready);
endinterface

[src/union_find_spanning_forest_unit.sv]
// Top level of the union-find spanning-forest unit: parent store in one RAM,
// root walks with path compression, link and saturating weight total.
// Depends on ufsf_pkg, ufsf_ifs (channels), ufsf_ram and assert_macros.svh.
//
//  channel   dir  payload                                     accepted when
//  in_edge   in   node_a, node_b, edge_weight, last_edge      valid & ready
//  out_res   out  joined, tree_weight                         valid & ready
//
// An accepted edge walks from node_a to its root (ST_FIND), walks the path again
// pointing each node at the root (ST_COMP), does the same for node_b and links
// in ST_LINK, which loads the output register; an out-of-range endpoint sends
// the edge straight to ST_LINK. The single RAM read port walks one hop per cycle.
// After reset, and after each edge marked last, the store is rewritten one
// entry per cycle, and no edge is taken until every entry is rewritten.
// A pending result in the output register does not block the next edge; only
// the link cycle waits for the output register to be free.
`include "assert_macros.svh"

module union_find_spanning_forest_unit
  import ufsf_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ufsf_edge_if.sink     in_edge,
  ufsf_result_if.source out_res
);

  localparam int AW = $clog2(NODES);

  ufsf_state_t state_r, state_nxt;

  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]       cur_r, cur_nxt;
  logic [AW-1:0]       root_r, root_nxt;
  logic [AW-1:0]       ra_r, ra_nxt;
  logic [AW-1:0]       node_a_r, node_a_nxt;
  logic [AW-1:0]       node_b_r, node_b_nxt;
  logic                side_r, side_nxt;
  logic                skip_r, skip_nxt;
  logic                last_r, last_nxt;
  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_joined_r, out_joined_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [AW-1:0] rd_data;

  logic               in_accept;
  logic               in_range;
  logic               out_free;
  logic               out_load;
  logic               link_join;
  logic [AW-1:0]      start_node;
  logic [TOTAL_W:0]   sum_wide;
  logic [TOTAL_W-1:0] sum_sat;

  ufsf_ram #(
    .WIDTH (AW),
    .DEPTH (NODES)
  ) u_parent_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign in_edge.ready = (state_r == ST_IDLE);
  assign in_accept     = in_edge.valid && in_edge.ready;
  assign in_range      = (32'(in_edge.node_a) < 32'(NODES)) &&
                         (32'(in_edge.node_b) < 32'(NODES));

  assign out_free   = !out_valid_r || out_res.ready;
  assign out_load   = (state_r == ST_LINK) && out_free;
  assign link_join  = !skip_r && (ra_r != root_r);
  assign start_node = side_r ? node_b_r : node_a_r;

  assign sum_wide = {1'b0, total_r} + (TOTAL_W + 1)'(weight_r);
  assign sum_sat  = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];

  assign out_res.valid       = out_valid_r;
  assign out_res.joined      = out_joined_r;
  assign out_res.tree_weight = out_total_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = in_range ? ST_FIND : ST_LINK;
        end
      end
      ST_FIND: begin
        if (rd_data == cur_r) begin
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        if (cur_r == root_r) begin
          state_nxt = side_r ? ST_LINK : ST_FIND;
        end
      end
      ST_LINK: begin
        if (out_free) begin
          state_nxt = last_r ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Datapath, RAM ports and outputs. In ST_FIND and ST_COMP the read data is
  // the parent of cur_r, and the next read address follows it directly.
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    cur_nxt        = cur_r;
    root_nxt       = root_r;
    ra_nxt         = ra_r;
    node_a_nxt     = node_a_r;
    node_b_nxt     = node_b_r;
    side_nxt       = side_r;
    skip_nxt       = skip_r;
    last_nxt       = last_r;
    weight_nxt     = weight_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_joined_nxt = out_joined_r;
    out_total_nxt  = out_total_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_r;
    ram_wdata      = root_r;
    ram_raddr      = cur_r;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = clr_cnt_r;
        if (clr_cnt_r == AW'(NODES - 1)) begin
          clr_cnt_nxt = '0;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        ram_raddr = AW'(in_edge.node_a);
        if (in_accept) begin
          node_a_nxt = AW'(in_edge.node_a);
          node_b_nxt = AW'(in_edge.node_b);
          weight_nxt = in_edge.edge_weight;
          last_nxt   = in_edge.last_edge;
          skip_nxt   = !in_range;
          cur_nxt    = AW'(in_edge.node_a);
          side_nxt   = 1'b0;
        end
      end
      ST_FIND: begin
        if (rd_data == cur_r) begin
          // Root reached; walk the same path again from its start.
          root_nxt  = cur_r;
          cur_nxt   = start_node;
          ram_raddr = start_node;
        end else begin
          cur_nxt   = rd_data;
          ram_raddr = rd_data;
        end
      end
      ST_COMP: begin
        if (cur_r == root_r) begin
          if (!side_r) begin
            ra_nxt    = root_r;
            side_nxt  = 1'b1;
            cur_nxt   = node_b_r;
            ram_raddr = node_b_r;
          end
        end else begin
          // Point this node at the root and read on; the read address is the
          // old parent, never the entry written in this cycle.
          ram_we    = 1'b1;
          ram_waddr = cur_r;
          ram_wdata = root_r;
          cur_nxt   = rd_data;
          ram_raddr = rd_data;
        end
      end
      ST_LINK: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_joined_nxt = link_join;
          out_total_nxt  = link_join ? sum_sat : total_r;
          if (link_join) begin
            ram_we    = 1'b1;
            ram_waddr = ra_r;
            ram_wdata = root_r;
            total_nxt = sum_sat;
          end
          if (last_r) begin
            total_nxt = '0;
          end
        end
      end
      default: begin
        clr_cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    root_r       <= root_nxt;
    ra_r         <= ra_nxt;
    node_a_r     <= node_a_nxt;
    node_b_r     <= node_b_nxt;
    side_r       <= side_nxt;
    skip_r       <= skip_nxt;
    last_r       <= last_nxt;
    weight_r     <= weight_nxt;
    out_joined_r <= out_joined_nxt;
    out_total_r  <= out_total_nxt;
  end

  `ASSERT_IMPL(a_comp_no_rw_clash, (state_r == ST_COMP) && ram_we, ram_waddr != ram_raddr, "compression write and read hit the same entry")
  `ASSERT_IMPL(a_load_only_in_link, out_valid_nxt && !out_valid_r, state_r == ST_LINK, "result loaded outside the link cycle")
  `ASSERT_NEXT(a_last_clears, out_load && last_r, (state_r == ST_CLEAR) && (total_r == '0) && (clr_cnt_r == '0), "last edge did not start a clean store")
  `ASSERT_IMPL(a_link_dist_roots, out_load && link_join, !skip_r && (ram_waddr == ra_r) && ram_we, "join without linking the first root")

endmodule

[src/ufsf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module ufsf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[dv/tb_union_find_spanning_forest_unit.sv]
// Testbench for union_find_spanning_forest_unit: directed edges, then random graphs,
// each result checked against its plan row's expected value or a union-find model kept in this file.
// Depends on ufsf_pkg, ufsf_ifs and the unit itself.
`timescale 1ns / 100ps

module tb_union_find_spanning_forest_unit
  import ufsf_pkg::*;
();

  localparam int NODE_COUNT   = NODES_DEF;
  localparam int RANDOM_EDGES = 1550;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int TAIL_CYCLES  = 100;
  localparam int PRINT_CAP    = 100;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic [NODE_W-1:0]   a;
    logic [NODE_W-1:0]   b;
    logic [WEIGHT_W-1:0] w;
    logic                last;
  } edge_item_t;

  typedef struct packed {
    logic               joined;
    logic [TOTAL_W-1:0] tree_weight;
  } result_t;

  // A row with fixed set carries its expected result; other rows use the model.
  typedef struct packed {
    logic [NODE_W-1:0]   a;
    logic [NODE_W-1:0]   b;
    logic [WEIGHT_W-1:0] w;
    logic                last;
    logic                fixed;
    logic                want_joined;
    logic [TOTAL_W-1:0]  want_total;
  } plan_row_t;

  localparam int PLAN_ROWS = 17;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{10'd0,     10'd1023,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 48'h0000_FFFF_FFFF},
    '{10'd1023,  10'd0,     32'h0000_0000, 1'b0, 1'b1, 1'b0, 48'h0000_FFFF_FFFF},
    '{10'd5,     10'd5,     32'h0000_0007, 1'b0, 1'b1, 1'b0, 48'h0000_FFFF_FFFF},
    '{10'd1,     10'd2,     32'h0000_0000, 1'b0, 1'b1, 1'b1, 48'h0000_FFFF_FFFF},
    '{10'd2,     10'd3,     32'h0000_0001, 1'b0, 1'b0, 1'b0, 48'h0},
    '{10'd3,     10'd4,     32'h0000_0002, 1'b0, 1'b0, 1'b0, 48'h0},
    '{10'd4,     10'd6,     32'h0000_0003, 1'b0, 1'b0, 1'b0, 48'h0},
    '{10'd1,     10'd0,     32'h0000_000A, 1'b0, 1'b0, 1'b0, 48'h0},
    '{10'h155,   10'h2AA,   32'h5555_5555, 1'b0, 1'b0, 1'b0, 48'h0},
    '{10'h2AA,   10'h155,   32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 48'h0},
    '{10'd1023,  10'd1,     32'h0000_0014, 1'b0, 1'b0, 1'b0, 48'h0},
    '{10'd7,     10'd8,     32'h8000_0000, 1'b1, 1'b0, 1'b0, 48'h0},
    '{10'd0,     10'd1023,  32'h0000_0003, 1'b0, 1'b1, 1'b1, 48'h0000_0000_0003},
    '{10'd9,     10'd9,     32'h0000_0001, 1'b1, 1'b1, 1'b0, 48'h0000_0000_0003},
    '{10'd1023,  10'd1022,  32'h5555_5555, 1'b0, 1'b1, 1'b1, 48'h0000_5555_5555},
    '{10'd1022,  10'd1023,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 48'h0000_5555_5555},
    '{10'd0,     10'd0,     32'h0000_0000, 1'b1, 1'b1, 1'b0, 48'h0000_5555_5555}
  };

  logic clk;
  logic rst_n;

  ufsf_edge_if   edge_ch ();
  ufsf_result_if res_ch ();

  union_find_spanning_forest_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_edge (edge_ch),
    .out_res (res_ch)
  );

  logic [NODE_W-1:0]  forest_parent [NODE_COUNT];
  logic [TOTAL_W-1:0] forest_total;
  result_t            results_due [$];
  int                 edges_sent;
  int                 mismatch_count;
  int                 cycle_count;

  // Both sides run without gaps over this stretch of edges.
  wire steady = (edges_sent >= 600) && (edges_sent < 950);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void clear_forest();
    for (int i = 0; i < NODE_COUNT; i++) forest_parent[i] = NODE_W'(i);
    forest_total = '0;
  endfunction

  // Finds the root of node and points every node on the walked path at it.
  function automatic logic [NODE_W-1:0] root_of(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] root;
    logic [NODE_W-1:0] cur;
    logic [NODE_W-1:0] nxt;
    int                hops;
    root = node;
    hops = 0;
    while (forest_parent[root] != root && hops < NODE_COUNT) begin
      root = forest_parent[root];
      hops++;
    end
    cur  = node;
    hops = 0;
    while (cur != root && hops < NODE_COUNT) begin
      nxt                = forest_parent[cur];
      forest_parent[cur] = root;
      cur                = nxt;
      hops++;
    end
    return root;
  endfunction

  function automatic result_t kruskal_accept(input edge_item_t e);
    logic [NODE_W-1:0] ra;
    logic [NODE_W-1:0] rb;
    result_t           res;
    res.joined = 1'b0;
    if (int'(e.a) < NODE_COUNT && int'(e.b) < NODE_COUNT) begin
      ra = root_of(e.a);
      rb = root_of(e.b);
      if (ra != rb) begin
        forest_parent[ra] = rb;
        if (forest_total > TOTAL_MAX - TOTAL_W'(e.w)) forest_total = TOTAL_MAX;
        else forest_total = forest_total + TOTAL_W'(e.w);
        res.joined = 1'b1;
      end
    end
    res.tree_weight = forest_total;
    if (e.last) clear_forest();
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic send_edge(input edge_item_t e, input logic fixed, input result_t want);
    result_t modeled;
    while (!steady && $urandom_range(0, 99) < 14) begin
      edge_ch.valid <= 1'b0;
      @(posedge clk);
    end
    edge_ch.valid       <= 1'b1;
    edge_ch.node_a      <= e.a;
    edge_ch.node_b      <= e.b;
    edge_ch.edge_weight <= e.w;
    edge_ch.last_edge   <= e.last;
    @(posedge clk);
    while (!edge_ch.ready) @(posedge clk);
    modeled = kruskal_accept(e);
    results_due.push_back(fixed ? want : modeled);
    edges_sent++;
  endtask

  // The last edge has just been accepted, so valid drops before waiting.
  task automatic drain_results();
    edge_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // One graph: windowed random edges, a chain that builds deep paths, edges over
  // the whole node range, or short noise with random last marks and weights.
  task automatic random_graph();
    int          kind;
    int          span;
    int          base;
    int          count;
    logic [32:0] w;
    edge_item_t  e;
    kind  = $urandom_range(0, 99);
    span  = (kind < 60) ? $urandom_range(2, 48) :
            (kind < 75) ? $urandom_range(8, 100) : NODE_COUNT;
    base  = $urandom_range(0, NODE_COUNT - span);
    count = (kind < 60) ? $urandom_range(1, 50) :
            (kind < 75) ? span + $urandom_range(2, 10) :
            (kind < 90) ? $urandom_range(1, 40) : $urandom_range(1, 3);
    w = (kind >= 90) ? 33'd0 : 33'($urandom_range(0, 255));
    for (int i = 0; i < count; i++) begin
      if (kind >= 90) begin
        w = {1'b0, $urandom()};
      end else if ($urandom_range(0, 3) != 0) begin
        w = w + ({1'b0, $urandom()} >> $urandom_range(4, 31));
        if (w[32]) w = 33'h0_FFFF_FFFF;
      end
      if (kind >= 60 && kind < 75 && i < span - 1) begin
        e.a = NODE_W'(base + i);
        e.b = NODE_W'(base + i + 1);
      end else if (kind >= 60 && kind < 75 && $urandom_range(0, 1) == 1) begin
        e.a = NODE_W'(base);
        e.b = NODE_W'(base + $urandom_range(0, span - 1));
      end else begin
        e.a = NODE_W'(base + $urandom_range(0, span - 1));
        e.b = NODE_W'(base + $urandom_range(0, span - 1));
      end
      e.w    = w[WEIGHT_W-1:0];
      e.last = (kind >= 90) ? ($urandom_range(0, 3) == 0) : (i == count - 1);
      send_edge(e, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : take_result
    result_t due;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result item with no edge outstanding");
      end else begin
        due = results_due.pop_front();
        if (res_ch.joined !== due.joined)
          report_mismatch($sformatf("joined %b, expected %b", res_ch.joined, due.joined));
        if (res_ch.tree_weight !== due.tree_weight)
          report_mismatch($sformatf("tree_weight %h, expected %h",
                                    res_ch.tree_weight, due.tree_weight));
      end
    end
    res_ch.ready <= steady || ($urandom_range(0, 99) >= 14);
  end

  initial begin
    edge_item_t e;
    result_t    want;
    bit         paused;
    paused              = 1'b0;
    edges_sent          = 0;
    mismatch_count      = 0;
    cycle_count         = 0;
    rst_n               = 1'b0;
    edge_ch.valid       = 1'b0;
    edge_ch.node_a      = '0;
    edge_ch.node_b      = '0;
    edge_ch.edge_weight = '0;
    edge_ch.last_edge   = 1'b0;
    res_ch.ready        = 1'b0;
    clear_forest();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      e.a              = PLAN[r].a;
      e.b              = PLAN[r].b;
      e.w              = PLAN[r].w;
      e.last           = PLAN[r].last;
      want.joined      = PLAN[r].want_joined;
      want.tree_weight = PLAN[r].want_total;
      send_edge(e, PLAN[r].fixed, want);
    end
    drain_results();

    while (edges_sent < PLAN_ROWS + RANDOM_EDGES) begin
      if (!paused && edges_sent >= 1100) begin
        drain_results();
        paused = 1'b1;
      end
      random_graph();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/ufsf_pkg.sv
src/ufsf_ifs.sv
src/ufsf_ram.sv
src/union_find_spanning_forest_unit.sv
dv/tb_union_find_spanning_forest_unit.sv
